[rtl/vaws_pkg.sv]
// Package for the voice allocator with stealing: field widths, operation and
// action codes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package vaws_pkg;

  localparam int OP_W    = 2;
  localparam int CH_W    = 4;
  localparam int SEQ_W   = 3;
  localparam int NOTE_W  = 7;
  localparam int PRIO_W  = 8;
  localparam int BEND_W  = 7;
  localparam int VOICE_W = 5;
  localparam int ENV_W   = 16;
  localparam int STAMP_W = 64;
  localparam int ACT_W   = 2;

  // Steal ranking key: priority, then envelope, then age stamp.
  localparam int KEY_W = PRIO_W + ENV_W + STAMP_W;

  localparam logic [BEND_W-1:0] BEND_CENTER = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_BEND     = 2'd2,
    OP_REPORT   = 2'd3
  } op_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_KEY_ON  = 2'd0,
    ACT_KEY_OFF = 2'd1,
    ACT_BEND    = 2'd2
  } act_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_STEAL,
    S_STEAL_WAIT,
    S_COMMIT_FREE,
    S_COMMIT_STEAL,
    S_MATCH,
    S_MATCH_WAIT,
    S_MATCH_END
  } state_e;

  typedef struct packed {
    logic accept;     // latch the request fields
    logic report_wr;  // apply a chip status report
    logic load_slot;  // free voice found at the scan index
    logic rd_en;      // read the voice table at the scan index
    logic commit;     // write the new voice and emit key-on
    logic stolen;     // the committed voice is the steal winner
    logic match_end;  // flush the held match as the final beat
  } cmd_t;

  typedef struct packed {
    logic seq_ok;     // request sequence is in range
    logic free_hit;   // voice at the scan index is free or silent
  } sts_t;

endpackage

`default_nettype wire

[rtl/vaws_ctrl.sv]
// Controller of the voice allocator: state machine and voice scan counter.
// Depends on vaws_pkg.
`default_nettype none

module vaws_ctrl #(
  parameter int VOICES = 24
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  input  wire  [vaws_pkg::OP_W-1:0]       operation_i,
  input  vaws_pkg::sts_t                  sts_i,
  output vaws_pkg::cmd_t                  cmd_o,
  output logic [$clog2(VOICES)-1:0]       idx_o,
  output logic                            busy_o
);

  localparam int VW = $clog2(VOICES);
  localparam logic [VW-1:0] LastIdx = VW'(VOICES - 1);

  vaws_pkg::state_e state_q, state_d;
  logic [VW-1:0]    cnt_q, cnt_d;
  vaws_pkg::op_e    op;
  logic             cnt_last;

  assign op       = vaws_pkg::op_e'(operation_i);
  assign cnt_last = (cnt_q == LastIdx);
  assign idx_o    = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vaws_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and scan counter.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      vaws_pkg::S_IDLE: begin
        cnt_d = '0;
        if (start_i && op != vaws_pkg::OP_REPORT && sts_i.seq_ok) begin
          if (op == vaws_pkg::OP_NOTE_ON) begin
            state_d = vaws_pkg::S_FREE;
          end else begin
            state_d = vaws_pkg::S_MATCH;
          end
        end
      end
      vaws_pkg::S_FREE: begin
        if (sts_i.free_hit) begin
          state_d = vaws_pkg::S_COMMIT_FREE;
        end else if (cnt_last) begin
          state_d = vaws_pkg::S_STEAL;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + VW'(1);
        end
      end
      vaws_pkg::S_STEAL: begin
        if (cnt_last) begin
          state_d = vaws_pkg::S_STEAL_WAIT;
        end else begin
          cnt_d = cnt_q + VW'(1);
        end
      end
      vaws_pkg::S_STEAL_WAIT: state_d = vaws_pkg::S_COMMIT_STEAL;
      vaws_pkg::S_COMMIT_FREE,
      vaws_pkg::S_COMMIT_STEAL: state_d = vaws_pkg::S_IDLE;
      vaws_pkg::S_MATCH: begin
        if (cnt_last) begin
          state_d = vaws_pkg::S_MATCH_WAIT;
        end else begin
          cnt_d = cnt_q + VW'(1);
        end
      end
      vaws_pkg::S_MATCH_WAIT: state_d = vaws_pkg::S_MATCH_END;
      vaws_pkg::S_MATCH_END:  state_d = vaws_pkg::S_IDLE;
      default:                state_d = vaws_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != vaws_pkg::S_IDLE);
    unique case (state_q)
      vaws_pkg::S_IDLE: begin
        cmd_o.accept    = start_i;
        cmd_o.report_wr = start_i && (op == vaws_pkg::OP_REPORT);
      end
      vaws_pkg::S_FREE:         cmd_o.load_slot = sts_i.free_hit;
      vaws_pkg::S_STEAL:        cmd_o.rd_en     = 1'b1;
      vaws_pkg::S_STEAL_WAIT:   cmd_o.rd_en     = 1'b0;
      vaws_pkg::S_COMMIT_FREE:  cmd_o.commit    = 1'b1;
      vaws_pkg::S_COMMIT_STEAL: begin
        cmd_o.commit = 1'b1;
        cmd_o.stolen = 1'b1;
      end
      vaws_pkg::S_MATCH:        cmd_o.rd_en     = 1'b1;
      vaws_pkg::S_MATCH_WAIT:   cmd_o.rd_en     = 1'b0;
      vaws_pkg::S_MATCH_END:    cmd_o.match_end = 1'b1;
      default:                  cmd_o           = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/vaws_dp.sv]
// Datapath of the voice allocator: voice table memories, live and sounding
// flags, steal ranking, match holding register and result registers.
// Depends on vaws_pkg.
`default_nettype none

module vaws_dp #(
  parameter int VOICES    = 24,
  parameter int SEQUENCES = 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  vaws_pkg::cmd_t                  cmd_i,
  input  wire  [$clog2(VOICES)-1:0]       idx_i,
  output vaws_pkg::sts_t                  sts_o,
  input  wire  [vaws_pkg::OP_W-1:0]       operation_i,
  input  wire  [vaws_pkg::CH_W-1:0]       channel_i,
  input  wire  [vaws_pkg::SEQ_W-1:0]      sequence_req_i,
  input  wire  [vaws_pkg::NOTE_W-1:0]     note_i,
  input  wire  [vaws_pkg::PRIO_W-1:0]     priority_req_i,
  input  wire  [vaws_pkg::BEND_W-1:0]     bend_value_i,
  input  wire  [vaws_pkg::VOICE_W-1:0]    report_voice_i,
  input  wire                             chip_active_i,
  input  wire  [vaws_pkg::ENV_W-1:0]      envelope_level_i,
  output logic                            result_strobe_o,
  output logic [vaws_pkg::ACT_W-1:0]      action_o,
  output logic [vaws_pkg::VOICE_W-1:0]    voice_o,
  output logic [vaws_pkg::BEND_W-1:0]     bend_out_o,
  output logic                            stolen_o,
  output logic                            last_o
);

  localparam int VW     = $clog2(VOICES);
  localparam int VoiceW = vaws_pkg::VOICE_W;
  localparam int StampW = vaws_pkg::STAMP_W;

  // Request fields held for the length of one item.
  vaws_pkg::op_e                  op_q;
  logic [vaws_pkg::CH_W-1:0]      ch_q;
  logic [vaws_pkg::SEQ_W-1:0]     seq_q;
  logic [vaws_pkg::NOTE_W-1:0]    note_q;
  logic [vaws_pkg::PRIO_W-1:0]    prio_q;
  logic [vaws_pkg::BEND_W-1:0]    bend_q;

  // Voice table.
  logic [vaws_pkg::CH_W-1:0]      ch_mem    [VOICES];
  logic [vaws_pkg::SEQ_W-1:0]     seq_mem   [VOICES];
  logic [vaws_pkg::NOTE_W-1:0]    note_mem  [VOICES];
  logic [vaws_pkg::PRIO_W-1:0]    prio_mem  [VOICES];
  logic [StampW-1:0]              stamp_mem [VOICES];
  logic [vaws_pkg::ENV_W-1:0]     env_mem   [VOICES];
  logic [VOICES-1:0]              live_q;
  logic [VOICES-1:0]              sounding_q;
  logic [StampW-1:0]              next_stamp_q;

  // Registered read port.
  logic [vaws_pkg::CH_W-1:0]      rd_ch_q;
  logic [vaws_pkg::SEQ_W-1:0]     rd_seq_q;
  logic [vaws_pkg::NOTE_W-1:0]    rd_note_q;
  logic [vaws_pkg::PRIO_W-1:0]    rd_prio_q;
  logic [StampW-1:0]              rd_stamp_q;
  logic [vaws_pkg::ENV_W-1:0]     rd_env_q;
  logic                           rd_live_q;
  logic [VW-1:0]                  rd_idx_q;
  logic                           rd_vld_q;

  // Steal ranking and match holding.
  logic [vaws_pkg::KEY_W-1:0]     best_key_q;
  logic [VW-1:0]                  best_idx_q;
  logic [VW-1:0]                  slot_q;
  logic                           pend_q;
  logic [VW-1:0]                  pend_idx_q;

  // Result registers.
  logic                           strobe_q;
  vaws_pkg::act_e                 act_q;
  logic [VW-1:0]                  voice_q;
  logic [vaws_pkg::BEND_W-1:0]    bend_out_q;
  logic                           stolen_q;
  logic                           last_q;

  logic                           rep_wr;
  logic [VW-1:0]                  rv_idx;
  logic [VW-1:0]                  cslot;
  logic [vaws_pkg::KEY_W-1:0]     rd_key;
  logic                           take_best;
  logic                           hit;
  vaws_pkg::act_e                 match_act;
  logic [vaws_pkg::BEND_W-1:0]    match_bend;
  logic                           emit;
  vaws_pkg::act_e                 e_act;
  logic [VW-1:0]                  e_voice;
  logic [vaws_pkg::BEND_W-1:0]    e_bend;
  logic                           e_stolen;
  logic                           e_last;

  assign sts_o.seq_ok   = (int'(sequence_req_i) < SEQUENCES);
  assign sts_o.free_hit = !(live_q[idx_i] && sounding_q[idx_i]);

  assign rep_wr = cmd_i.report_wr && (int'(report_voice_i) < VOICES);
  assign rv_idx = VW'(report_voice_i);
  assign cslot  = cmd_i.stolen ? best_idx_q : slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= vaws_pkg::op_e'(operation_i);
      ch_q   <= channel_i;
      seq_q  <= sequence_req_i;
      note_q <= note_i;
      prio_q <= priority_req_i;
      bend_q <= bend_value_i;
    end
    if (cmd_i.load_slot) begin
      slot_q <= idx_i;
    end
  end

  // Table writes share one address: the committed voice or the reported one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ch_mem[cslot]    <= ch_q;
      seq_mem[cslot]   <= seq_q;
      note_mem[cslot]  <= note_q;
      prio_mem[cslot]  <= prio_q;
      stamp_mem[cslot] <= next_stamp_q;
      env_mem[cslot]   <= '0;
    end else if (rep_wr) begin
      env_mem[rv_idx]  <= envelope_level_i;
    end
    if (cmd_i.rd_en) begin
      rd_ch_q    <= ch_mem[idx_i];
      rd_seq_q   <= seq_mem[idx_i];
      rd_note_q  <= note_mem[idx_i];
      rd_prio_q  <= prio_mem[idx_i];
      rd_stamp_q <= stamp_mem[idx_i];
      rd_env_q   <= env_mem[idx_i];
      rd_live_q  <= live_q[idx_i];
      rd_idx_q   <= idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q       <= '0;
      sounding_q   <= '0;
      next_stamp_q <= StampW'(1);
      rd_vld_q     <= 1'b0;
      pend_q       <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.commit) begin
        live_q[cslot]     <= 1'b1;
        sounding_q[cslot] <= 1'b1;
        next_stamp_q      <= next_stamp_q + StampW'(1);
      end else if (rep_wr) begin
        sounding_q[rv_idx] <= chip_active_i;
      end
      if (cmd_i.accept) begin
        pend_q <= 1'b0;
      end else if (hit) begin
        pend_q <= 1'b1;
      end
    end
  end

  // Steal ranking: a strictly smaller key wins, so ties keep the lower index.
  assign rd_key    = {rd_prio_q, rd_env_q, rd_stamp_q};
  assign take_best = rd_vld_q && (op_q == vaws_pkg::OP_NOTE_ON) &&
                     ((rd_idx_q == '0) || (rd_key < best_key_q));

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_key_q <= rd_key;
      best_idx_q <= rd_idx_q;
    end
    if (hit) begin
      pend_idx_q <= rd_idx_q;
    end
  end

  assign hit = rd_vld_q && (op_q != vaws_pkg::OP_NOTE_ON) && rd_live_q &&
               (rd_ch_q == ch_q) && (rd_seq_q == seq_q) &&
               ((op_q == vaws_pkg::OP_BEND) || (rd_note_q == note_q));

  assign match_act  = (op_q == vaws_pkg::OP_BEND) ? vaws_pkg::ACT_BEND
                                                  : vaws_pkg::ACT_KEY_OFF;
  assign match_bend = (op_q == vaws_pkg::OP_BEND) ? bend_q : vaws_pkg::BEND_CENTER;

  // A match is held in a register until the next match or the end of the scan, so that the final beat can carry last.
  always_comb begin
    emit     = 1'b0;
    e_act    = vaws_pkg::ACT_KEY_ON;
    e_voice  = cslot;
    e_bend   = vaws_pkg::BEND_CENTER;
    e_stolen = 1'b0;
    e_last   = 1'b0;
    if (cmd_i.commit) begin
      emit     = 1'b1;
      e_stolen = cmd_i.stolen;
      e_last   = 1'b1;
    end else if (hit && pend_q) begin
      emit    = 1'b1;
      e_act   = match_act;
      e_voice = pend_idx_q;
      e_bend  = match_bend;
    end else if (cmd_i.match_end && pend_q) begin
      emit    = 1'b1;
      e_act   = match_act;
      e_voice = pend_idx_q;
      e_bend  = match_bend;
      e_last  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      act_q      <= e_act;
      voice_q    <= e_voice;
      bend_out_q <= e_bend;
      stolen_q   <= e_stolen;
      last_q     <= e_last;
    end
  end

  assign result_strobe_o = strobe_q;
  assign action_o        = act_q;
  assign voice_o         = VoiceW'(voice_q);
  assign bend_out_o      = bend_out_q;
  assign stolen_o        = stolen_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

[rtl/voice_allocator_with_stealing_top.sv]
// Top level of the polyphonic voice allocator with priority stealing.
// Instantiates vaws_ctrl and vaws_dp; depends on vaws_pkg.
`default_nettype none

// Usage
// An event beat is taken at a rising edge with start_i high and busy_o low.
// Chip status reports (operation 3) are applied in that same edge, leave
// busy_o low and give no result, so reports can arrive every cycle.
// Note-on scans the live/sounding flags one voice per cycle for the first
// free or silent voice; the key-on result appears in the cycle after
// busy_o falls. When every voice is live and sounding, a second pass
// reads the voice table memory, through its single read port, one entry
// per cycle to rank the steal candidates.
// Note-off and bend scan the table once: the matching voices come out in
// ascending order, at most one beat per cycle, the final one marked by
// last_o. No match gives no beat.
// Each result beat sits on the result ports for exactly one cycle, marked
// by result_strobe_o; the receiver cannot stall, so nothing is held back.
// Events with an out-of-range sequence are dropped without going busy.
// Reset clears all voices to free and the age stamp to one; the block is
// ready for an event in the first cycle after reset.

module voice_allocator_with_stealing_top #(
  parameter int VOICES    = 24,
  parameter int SEQUENCES = 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  output logic                            busy_o,
  input  wire  [vaws_pkg::OP_W-1:0]       operation_i,
  input  wire  [vaws_pkg::CH_W-1:0]       channel_i,
  input  wire  [vaws_pkg::SEQ_W-1:0]      sequence_req_i,
  input  wire  [vaws_pkg::NOTE_W-1:0]     note_i,
  input  wire  [vaws_pkg::PRIO_W-1:0]     priority_req_i,
  input  wire  [vaws_pkg::BEND_W-1:0]     bend_value_i,
  input  wire  [vaws_pkg::VOICE_W-1:0]    report_voice_i,
  input  wire                             chip_active_i,
  input  wire  [vaws_pkg::ENV_W-1:0]      envelope_level_i,
  output logic                            result_strobe_o,
  output logic [vaws_pkg::ACT_W-1:0]      action_o,
  output logic [vaws_pkg::VOICE_W-1:0]    voice_o,
  output logic [vaws_pkg::BEND_W-1:0]     bend_out_o,
  output logic                            stolen_o,
  output logic                            last_o
);

  vaws_pkg::cmd_t            cmd;
  vaws_pkg::sts_t            sts;
  logic [$clog2(VOICES)-1:0] idx;

  vaws_ctrl #(
    .VOICES(VOICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .idx_o       (idx),
    .busy_o      (busy_o)
  );

  vaws_dp #(
    .VOICES    (VOICES),
    .SEQUENCES (SEQUENCES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .idx_i            (idx),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .channel_i        (channel_i),
    .sequence_req_i   (sequence_req_i),
    .note_i           (note_i),
    .priority_req_i   (priority_req_i),
    .bend_value_i     (bend_value_i),
    .report_voice_i   (report_voice_i),
    .chip_active_i    (chip_active_i),
    .envelope_level_i (envelope_level_i),
    .result_strobe_o  (result_strobe_o),
    .action_o         (action_o),
    .voice_o          (voice_o),
    .bend_out_o       (bend_out_o),
    .stolen_o         (stolen_o),
    .last_o           (last_o)
  );

  // A result beat only follows a cycle in which the block was working.
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy_o))
    else $error("result beat without preceding busy cycle");

  // A key-on is always the only, and therefore the final, beat of its event.
  a_key_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && action_o == vaws_pkg::ACT_KEY_ON) |-> last_o)
    else $error("key-on beat without last");

  // Only key-on beats may report a stolen voice.
  a_stolen_key_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && stolen_o) |-> (action_o == vaws_pkg::ACT_KEY_ON))
    else $error("stolen flag on a non key-on beat");

  // An accepted in-range note-on always makes the block busy.
  a_note_on_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i == vaws_pkg::OP_NOTE_ON &&
     int'(sequence_req_i) < SEQUENCES) |=> busy_o)
    else $error("note-on accepted without starting a scan");

  // Voice indexes on the result ports stay inside the table.
  a_voice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (int'(voice_o) < VOICES))
    else $error("result voice index out of range");

endmodule

`default_nettype wire
